### rtl/core/clns_pkg.sv
// Shared types, constants and lookup functions for the character LCD nibble sequencer.
package clns_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned IN_DW    = 16;
  localparam int unsigned OUT_DW   = 8;
  localparam int unsigned CFG_IW   = 2;
  localparam int unsigned CFG_DW   = 6;

  typedef enum logic [REQ_W-1:0] {
    REQ_CMD    = 3'd0,
    REQ_DATA   = 3'd1,
    REQ_CURSOR = 3'd2,
    REQ_CLEAR  = 3'd3,
    REQ_INIT   = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    WC_NONE     = 3'd0,
    WC_LOW_NIB  = 3'd1,
    WC_COMMAND  = 3'd2,
    WC_CLEAR    = 3'd3,
    WC_POSITION = 3'd4,
    WC_CMD_1MS  = 3'd5
  } wait_class_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_LINE_WIDTH  = 2'd0,
    CFG_LINE_COUNT  = 2'd1,
    CFG_CURSOR_MODE = 2'd2
  } cfg_idx_e;

  localparam logic [5:0] LINE_WIDTH_RST  = 6'd16;
  localparam logic [2:0] LINE_COUNT_RST  = 3'd2;
  localparam logic [1:0] CURSOR_MODE_RST = 2'd0;

  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_DISP_ON  = 8'b0000_1100;
  localparam logic [3:0] INIT_LAST_FULL  = 4'd8;
  localparam logic [3:0] INIT_LAST_SHORT = 4'd7;

  typedef struct packed {
    logic [5:0] line_width;
    logic [2:0] line_count;
    logic [1:0] cursor_mode;
  } cfg_t;

  // value holds the byte, or the cursor mode in bits 1:0 for init
  typedef struct packed {
    req_e       kind;
    logic [7:0] value;
    logic       init_full;
  } job_t;

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] b;
    unique case (row)
      2'd0: b = 8'h80;
      2'd1: b = 8'hC0;
      2'd2: b = 8'h94;
      default: b = 8'hD4;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] init_byte(input logic [3:0] idx, input logic [1:0] mode);
    logic [7:0] b;
    unique case (idx)
      4'd0: b = 8'h33;
      4'd1: b = 8'h32;
      4'd2: b = 8'h28;
      4'd3: b = 8'h0E;
      4'd4: b = CMD_CLEAR;
      4'd5: b = 8'h06;
      4'd6: b = CMD_DISP_ON | {6'd0, mode};
      4'd7: b = CMD_CLEAR;
      default: b = 8'h80;
    endcase
    return b;
  endfunction

  function automatic wait_class_e init_lo_class(input logic [3:0] idx);
    wait_class_e c;
    unique case (idx)
      4'd0, 4'd1, 4'd2, 4'd3: c = WC_COMMAND;
      4'd5:                   c = WC_CMD_1MS;
      4'd4, 4'd6, 4'd7:       c = WC_CLEAR;
      default:                c = WC_POSITION;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/clns_front.sv
// Request intake: range checks and classification of requests into nibble jobs.
module clns_front (
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [clns_pkg::IN_DW-1:0] s_axis_tdata,
  input  logic [clns_pkg::REQ_W-1:0] s_axis_tuser,
  input  clns_pkg::cfg_t             cfg_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output clns_pkg::job_t             job_o
);

  logic [7:0] byte_value;
  logic [5:0] column;
  logic [1:0] row;
  logic       cursor_ok;
  logic       keep;

  assign byte_value = s_axis_tdata[7:0];
  assign column     = s_axis_tdata[13:8];
  assign row        = s_axis_tdata[15:14];

  assign cursor_ok = (column < cfg_i.line_width) && ({1'b0, row} < cfg_i.line_count);

  assign s_axis_tready = !q_full_i;

  always_comb begin
    job_o.kind      = clns_pkg::REQ_CMD;
    job_o.value     = byte_value;
    job_o.init_full = (cfg_i.line_width != 6'd0) && (cfg_i.line_count != 3'd0);
    keep            = 1'b1;
    unique case (s_axis_tuser)
      clns_pkg::REQ_CMD: begin
        job_o.kind = clns_pkg::REQ_CMD;
      end
      clns_pkg::REQ_DATA: begin
        job_o.kind = clns_pkg::REQ_DATA;
      end
      clns_pkg::REQ_CURSOR: begin
        job_o.kind  = clns_pkg::REQ_CURSOR;
        job_o.value = clns_pkg::row_base(row) + {2'd0, column};
        keep        = cursor_ok;
      end
      clns_pkg::REQ_CLEAR: begin
        job_o.kind  = clns_pkg::REQ_CLEAR;
        job_o.value = clns_pkg::CMD_CLEAR;
      end
      clns_pkg::REQ_INIT: begin
        job_o.kind  = clns_pkg::REQ_INIT;
        job_o.value = {6'd0, cfg_i.cursor_mode};
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = s_axis_tvalid && !q_full_i && keep;

endmodule

### rtl/core/clns_queue.sv
// Small job FIFO between request intake and nibble emission.
module clns_queue #(
  parameter int unsigned DEPTH = clns_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  clns_pkg::job_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output clns_pkg::job_t head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  clns_pkg::job_t mem_q [DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_push;
  logic           do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### rtl/core/clns_back.sv
// Nibble emission: walks each job one nibble per beat into a registered output.
module clns_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  clns_pkg::job_t              job_i,
  output logic                        pop_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [clns_pkg::OUT_DW-1:0] m_axis_tdata,  // [3:0] nibble, [6:4] wait_class
  output logic                        m_axis_tuser,  // reg_select
  output logic                        m_axis_tlast
);

  logic [4:0]            step_q, step_d;
  logic                  valid_q;
  logic [3:0]            nib_q;
  clns_pkg::wait_class_e wc_q;
  logic                  rs_q;
  logic                  last_q;

  logic [3:0]            byte_idx;
  logic [3:0]            last_idx;
  logic [7:0]            cur_byte;
  logic                  rs;
  clns_pkg::wait_class_e wc_hi, wc_lo, wc;
  logic [3:0]            nib;
  logic                  is_last;
  logic                  load_ok;
  logic                  advance;

  assign byte_idx = step_q[4:1];

  always_comb begin
    cur_byte = job_i.value;
    rs       = 1'b0;
    wc_hi    = clns_pkg::WC_LOW_NIB;
    wc_lo    = clns_pkg::WC_NONE;
    last_idx = 4'd0;
    unique case (job_i.kind)
      clns_pkg::REQ_CMD: begin
        wc_lo = clns_pkg::WC_NONE;
      end
      clns_pkg::REQ_DATA: begin
        rs    = 1'b1;
        wc_hi = clns_pkg::WC_NONE;
      end
      clns_pkg::REQ_CURSOR: begin
        wc_lo = clns_pkg::WC_POSITION;
      end
      clns_pkg::REQ_CLEAR: begin
        wc_lo = clns_pkg::WC_CLEAR;
      end
      clns_pkg::REQ_INIT: begin
        cur_byte = clns_pkg::init_byte(byte_idx, job_i.value[1:0]);
        wc_lo    = clns_pkg::init_lo_class(byte_idx);
        last_idx = job_i.init_full ? clns_pkg::INIT_LAST_FULL : clns_pkg::INIT_LAST_SHORT;
      end
      default: begin
        wc_lo = clns_pkg::WC_NONE;
      end
    endcase
    nib     = step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
    wc      = step_q[0] ? wc_lo : wc_hi;
    is_last = step_q[0] && (byte_idx == last_idx);
  end

  assign load_ok = !valid_q || m_axis_tready;
  assign advance = job_valid_i && load_ok;
  assign pop_o   = advance && is_last;

  always_comb begin
    step_d = step_q;
    if (advance) begin
      step_d = is_last ? 5'd0 : step_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 5'd0;
      valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load_ok) begin
        valid_q <= job_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      nib_q  <= nib;
      wc_q   <= wc;
      rs_q   <= rs;
      last_q <= is_last;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {1'b0, wc_q, nib_q};
  assign m_axis_tuser  = rs_q;
  assign m_axis_tlast  = last_q;

endmodule

### rtl/core/char_lcd_nibble_sequencer.sv
// Top level of the character LCD 4-bit nibble sequencer.
// An accepted request is written into the job queue, and its first nibble is then registered
// at the output. Throughput: one nibble per cycle from the emission stage while m_axis_tready
// holds; two nibbles per byte request, 16 or 18 per init. Intake runs ahead through a job queue.
// Reset: config to width 16, 2 lines, cursor mode 0; queue and output empty.
module char_lcd_nibble_sequencer #(
  parameter int unsigned QUEUE_DEPTH = clns_pkg::QUEUE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [clns_pkg::IN_DW-1:0]  s_axis_tdata,  // [7:0] byte_value, [13:8] column, [15:14] row
  input  logic [clns_pkg::REQ_W-1:0]  s_axis_tuser,  // [2:0] req_type
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [clns_pkg::OUT_DW-1:0] m_axis_tdata,  // [3:0] nibble, [6:4] wait_class, [7] zero
  output logic                        m_axis_tuser,  // [0] reg_select
  output logic                        m_axis_tlast,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [clns_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [clns_pkg::CFG_DW-1:0] cfg_data_i
);

  clns_pkg::cfg_t cfg_q;
  clns_pkg::job_t push_job;
  clns_pkg::job_t head_job;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width  <= clns_pkg::LINE_WIDTH_RST;
      cfg_q.line_count  <= clns_pkg::LINE_COUNT_RST;
      cfg_q.cursor_mode <= clns_pkg::CURSOR_MODE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        clns_pkg::CFG_LINE_WIDTH:  cfg_q.line_width  <= cfg_data_i[5:0];
        clns_pkg::CFG_LINE_COUNT:  cfg_q.line_count  <= cfg_data_i[2:0];
        clns_pkg::CFG_CURSOR_MODE: cfg_q.cursor_mode <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  clns_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_i         (cfg_q),
    .q_full_i      (q_full),
    .push_o        (push),
    .job_o         (push_job)
  );

  clns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (head_job)
  );

  clns_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (!q_empty),
    .job_i         (head_job),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_data_no_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[6:4] == clns_pkg::WC_NONE))
    else $error("data beat carries a wait class");

  a_last_is_low_nibble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[6:4] != clns_pkg::WC_LOW_NIB))
    else $error("final beat of a request marked as high nibble");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("job popped from empty queue");

  a_push_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !q_empty)
    else $error("queue empty right after a push");
`endif

endmodule
